// ----- design/tekp_pkg.sv -----
// shared types, character constants and helpers for the terminal escape key parser
package tekp_pkg;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_ESC     = 2'd1,
      KIND_NEWLINE = 2'd2,
      KIND_CHAR    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [20:0] out_char;
      logic [3:0]  seq_len;
      logic [63:0] seq_bytes;
   } result_type;

   localparam int CP_W     = 21;
   localparam int REPORT_BYTES = 8;

   localparam logic [CP_W-1:0] CP_ESC  = 21'h00001b;
   localparam logic [CP_W-1:0] CP_LBR  = 21'h00005b;
   localparam logic [CP_W-1:0] CP_O    = 21'h00004f;
   localparam logic [CP_W-1:0] CP_LF   = 21'h00000a;
   localparam logic [CP_W-1:0] CP_CR   = 21'h00000d;
   localparam logic [CP_W-1:0] CP_ZERO = 21'h000030;
   localparam logic [CP_W-1:0] CP_NINE = 21'h000039;
   localparam logic [CP_W-1:0] CP_SEMI = 21'h00003b;

   localparam logic [7:0] BYTE_ESC = 8'h1b;
   localparam logic [7:0] BYTE_LBR = 8'h5b;
   localparam logic [7:0] BYTE_O   = 8'h4f;

   // letters and symbols that close a sequence
   function automatic logic is_terminator(input logic [CP_W-1:0] c);
      logic hit;
      hit = 1'b0;
      if (c >= 21'h000061 && c <= 21'h000065) hit = 1'b1;
      if (c >= 21'h000041 && c <= 21'h000049) hit = 1'b1;
      if (c == 21'h00004b || c == 21'h00004d || c == 21'h00004e) hit = 1'b1;
      if (c >= 21'h000050 && c <= 21'h00005a) hit = 1'b1;
      if (c == 21'h00007e || c == 21'h000024 || c == 21'h00005e) hit = 1'b1;
      return hit;
   endfunction

endpackage

// ----- design/terminal_escape_key_parser.sv -----
// top level: input register, decode, parser state and result register
//
// Usage:
//   req channel carries one decoded keyboard character per word: code point in
//   req_tdata, empty/invalid marker in req_tuser. Every accepted word yields
//   exactly one rsp word: kind in rsp_tuser, the passed-through character,
//   sequence length and sequence bytes in rsp_tdata.
//   An ESC starts a pending escape; following ASCII bytes collect in a buffer
//   of MAX_SEQ_BYTES until a terminator completes the sequence, which is then
//   reported as an escape word. CR and LF outside a sequence report newline.
//   The input register captures a word on acceptance; the result register captures
//   its result once it is free, and rsp_tvalid rises with it.
//   Throughput: one word per cycle while rsp_tready is high, set by the single
//   decode stage that reads and updates the parser state in one pass.
//   Reset clears both pipeline stages, the escape flag and the buffer.
//   When rsp_tready is low the result register holds; one more word may sit
//   in the input register, after which req_tready drops until the result
//   is taken. No word is dropped or duplicated under stalls.
module terminal_escape_key_parser
   import tekp_pkg::*;
#(
   parameter int MAX_SEQ_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] key_code, rest zero
   input  logic [0:0]  req_tuser,   // [0] is_empty
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [20:0] out_char, [24:21] seq_len, [88:25] seq_bytes
   output logic [1:0]  rsp_tuser    // [1:0] kind
);

   localparam int CNT_W = $clog2(MAX_SEQ_BYTES + 1);

   logic                          in_valid_ff;
   logic                          in_empty_ff;
   logic [CP_W-1:0]               in_cp_ff;
   logic                          out_valid_ff;
   result_type                    out_res_ff;
   logic                          pend_ff;
   logic [MAX_SEQ_BYTES-1:0][7:0] buf_ff;
   logic [CNT_W-1:0]              cnt_ff;

   logic                          pend_in;
   logic [MAX_SEQ_BYTES-1:0][7:0] buf_in;
   logic [CNT_W-1:0]              cnt_in;
   result_type                    res_in;
   logic                          out_free;
   logic                          advance;
   logic                          req_take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   tekp_step #(
      .MAX_SEQ_BYTES (MAX_SEQ_BYTES),
      .CNT_W         (CNT_W)
   ) u_step (
      .is_empty   (in_empty_ff),
      .key_code   (in_cp_ff),
      .pend       (pend_ff),
      .seq_buf    (buf_ff),
      .seq_cnt    (cnt_ff),
      .next_pend  (pend_in),
      .next_buf   (buf_in),
      .next_cnt   (cnt_in),
      .res        (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         buf_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            pend_ff      <= pend_in;
            buf_ff       <= buf_in;
            cnt_ff       <= cnt_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_empty_ff <= req_tuser[0];
         in_cp_ff    <= req_tdata[CP_W-1:0];
      end
      if (advance) begin
         out_res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_res_ff.seq_bytes, out_res_ff.seq_len, out_res_ff.out_char};
   assign rsp_tuser  = out_res_ff.kind;

endmodule

// ----- design/tekp_step.sv -----
// one-word decode: result and next parser state from the current state and a character
module tekp_step
   import tekp_pkg::*;
#(
   parameter int MAX_SEQ_BYTES = 8,
   parameter int CNT_W         = 4
) (
   input  logic                           is_empty,
   input  logic [CP_W-1:0]                key_code,
   input  logic                           pend,
   input  logic [MAX_SEQ_BYTES-1:0][7:0]  seq_buf,
   input  logic [CNT_W-1:0]               seq_cnt,
   output logic                           next_pend,
   output logic [MAX_SEQ_BYTES-1:0][7:0]  next_buf,
   output logic [CNT_W-1:0]               next_cnt,
   output result_type                     res
);

   localparam int REP_N = (MAX_SEQ_BYTES < REPORT_BYTES) ? MAX_SEQ_BYTES : REPORT_BYTES;

   logic [MAX_SEQ_BYTES-1:0][7:0] app_buf;
   logic [MAX_SEQ_BYTES-1:0][7:0] rep_buf;
   logic [CNT_W-1:0]              app_cnt;
   logic [CNT_W-1:0]              rep_cnt;
   logic [4:0]                    rep_cnt_ext;
   logic                          do_append;
   logic                          do_report;
   logic                          report_app;
   logic                          is_esc;
   logic                          cnt_one;
   logic                          cnt_two;
   logic                          head_esc;
   logic                          head_lbr;
   logic                          is_digit;

   assign is_esc   = (key_code == CP_ESC);
   assign cnt_one  = (seq_cnt == CNT_W'(1));
   assign cnt_two  = (seq_cnt == CNT_W'(2));
   assign head_esc = (seq_buf[0] == BYTE_ESC);
   assign head_lbr = (seq_buf[0] == BYTE_LBR);
   assign is_digit = (key_code >= CP_ZERO && key_code <= CP_NINE);
   assign app_cnt  = seq_cnt + CNT_W'(1);

   // buffer with the character written at the fill position
   always_comb begin
      app_buf = seq_buf;
      for (int i = 0; i < MAX_SEQ_BYTES; i++) begin
         if (seq_cnt == CNT_W'(i)) app_buf[i] = key_code[7:0];
      end
   end

   always_comb begin
      next_pend  = pend;
      next_buf   = seq_buf;
      next_cnt   = seq_cnt;
      do_append  = 1'b0;
      do_report  = 1'b0;
      report_app = 1'b0;
      res        = '0;
      res.kind   = KIND_NONE;

      priority if ((is_empty || is_esc) && pend && cnt_one) begin
         // lone escape
         next_pend = 1'b0;
         next_buf  = '0;
         next_cnt  = '0;
         res.kind  = KIND_ESC;
      end else if (is_empty) begin
         next_pend = pend;
      end else if (is_esc) begin
         next_buf = '0;
         if (!pend) begin
            next_pend   = 1'b1;
            next_buf[0] = BYTE_ESC;
            next_cnt    = CNT_W'(1);
         end else begin
            next_cnt = '0;
            res.kind = KIND_ESC;
         end
      end else if (seq_cnt != '0) begin
         next_pend = 1'b0;
         priority if (seq_cnt >= CNT_W'(MAX_SEQ_BYTES)) begin
            // overflow abort
            next_buf = '0;
            next_cnt = '0;
         end else if ((key_code == CP_LBR || key_code == CP_O) && head_esc) begin
            next_buf    = '0;
            next_buf[0] = key_code[7:0];
            next_cnt    = CNT_W'(1);
         end else if (key_code == CP_LF) begin
            res.kind = KIND_NEWLINE;
         end else if (key_code == CP_LBR) begin
            if (cnt_one && head_lbr) begin
               do_append = 1'b1;
            end else begin
               do_report  = 1'b1;
               report_app = cnt_two && head_lbr && (seq_buf[1] == BYTE_O);
            end
         end else if (is_digit || key_code == CP_SEMI) begin
            do_append = 1'b1;
         end else if (key_code == CP_O) begin
            if (cnt_two && head_lbr && (seq_buf[1] == BYTE_LBR)) begin
               do_report  = 1'b1;
               report_app = 1'b1;
            end else begin
               do_append = 1'b1;
            end
         end else if (is_terminator(key_code)) begin
            do_report  = 1'b1;
            report_app = 1'b1;
         end else begin
            // bad sequence, character dropped
            do_report = 1'b1;
         end
      end else begin
         next_pend = 1'b0;
         if (key_code == CP_CR || key_code == CP_LF) begin
            res.kind = KIND_NEWLINE;
         end else begin
            res.kind     = KIND_CHAR;
            res.out_char = key_code;
         end
      end

      if (do_append) begin
         next_buf = app_buf;
         next_cnt = app_cnt;
      end

      rep_buf     = report_app ? app_buf : seq_buf;
      rep_cnt     = report_app ? app_cnt : seq_cnt;
      rep_cnt_ext = 5'(rep_cnt);

      if (do_report) begin
         res.kind    = KIND_ESC;
         res.seq_len = (rep_cnt_ext > 5'd8) ? 4'd8 : rep_cnt_ext[3:0];
         // bytes past the count are always zero in the buffer
         for (int k = 0; k < REP_N; k++) begin
            res.seq_bytes[8*k +: 8] = rep_buf[k];
         end
         next_buf = '0;
         next_cnt = '0;
      end
   end

endmodule

// ----- design/tekp_checker.sv -----
// port-level checker for the terminal escape key parser and its bind
module tekp_checker
   import tekp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // every accepted word is followed by a valid result; the check makes no allowance for a stalled output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("accepted word produced no result");

   // only escape words carry sequence fields
   a_seq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_ESC |-> rsp_tdata[88:21] == '0)
      else $error("sequence fields set outside an escape word");

   // only passed-through characters carry a code point, and outside them the length stays within eight
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_CHAR |-> rsp_tdata[20:0] == '0 && rsp_tdata[24:21] <= 4'd8)
      else $error("bad character or length field");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind terminal_escape_key_parser tekp_checker u_tekp_checker (.*);
